// ----- design/xcfb_pkg.sv -----
// Shared types and constants for the XOR-checked frame builder.
`timescale 1ns / 1ps

package xcfb_pkg;

  // Input opcodes
  localparam logic OP_START = 1'b0;
  localparam logic OP_DATA  = 1'b1;

  // Configuration register indexes
  localparam logic REG_MASTER_TOKEN = 1'b0;
  localparam logic REG_SLAVE_TOKEN  = 1'b1;

  // Frame constants
  localparam logic [7:0] FRAME_FLAG = 8'h7E;
  localparam logic [7:0] LEN_OFFSET = 8'd4;

  // Job queue depth between front and back (power of two)
  localparam int JQ_DEPTH = 4;

  // Sequencer step counter width (longest run is eight bytes)
  localparam int STEP_W = 3;

  typedef enum logic [1:0] {
    JOB_ERR,
    JOB_START,
    JOB_DATA
  } job_kind_t;

  typedef enum logic [3:0] {
    SEL_FLAG,
    SEL_LEN4,
    SEL_CMD,
    SEL_LEN,
    SEL_MTOK,
    SEL_STOK,
    SEL_DATA,
    SEL_XOR,
    SEL_CLOSE,
    SEL_ERR
  } byte_sel_t;

  // One classified item as handed from front to back
  typedef struct packed {
    job_kind_t  kind;
    logic [7:0] command;
    logic [6:0] length;
    logic [7:0] data;
    logic       trailer;   // frame closes after this item
  } job_t;

endpackage

// ----- design/xcfb_front.sv -----
// Front end: accepts items, tracks frame state and classifies each item into a job.
`timescale 1ns / 1ps

module xcfb_front #(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic             opcode,
  input  logic [7:0]       command,
  input  logic [6:0]       payload_length,
  input  logic [7:0]       data_byte,
  output xcfb_pkg::job_t   job
);
  import xcfb_pkg::*;

  logic       frame_open_r, frame_open_nxt;
  logic [6:0] bytes_left_r, bytes_left_nxt;
  logic       len_bad;

  assign len_bad = {1'b0, payload_length} > 8'(MAX_PAYLOAD);

  // Classify and compute the next frame state
  always_comb begin
    frame_open_nxt = frame_open_r;
    bytes_left_nxt = bytes_left_r;
    job.kind       = JOB_ERR;
    job.command    = command;
    job.length     = payload_length;
    job.data       = data_byte;
    job.trailer    = 1'b0;
    if (opcode == OP_START) begin
      if (!len_bad) begin
        job.kind       = JOB_START;
        job.trailer    = (payload_length == 7'd0);
        frame_open_nxt = (payload_length != 7'd0);
        bytes_left_nxt = payload_length;
      end
    end else if (frame_open_r) begin
      job.kind       = JOB_DATA;
      job.trailer    = (bytes_left_r == 7'd1);
      frame_open_nxt = (bytes_left_r != 7'd1);
      bytes_left_nxt = bytes_left_r - 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_open_r <= 1'b0;
      bytes_left_r <= 7'd0;
    end else if (accept) begin
      frame_open_r <= frame_open_nxt;
      bytes_left_r <= bytes_left_nxt;
    end
  end

endmodule

// ----- design/xcfb_job_fifo.sv -----
// Short job queue that decouples the front end from the byte sequencer.
`timescale 1ns / 1ps

module xcfb_job_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  xcfb_pkg::job_t wr_job,
  input  logic           rd_en,
  output xcfb_pkg::job_t rd_job,
  output logic           full,
  output logic           empty
);
  import xcfb_pkg::*;

  localparam int PTR_W = $clog2(JQ_DEPTH);
  localparam int CNT_W = $clog2(JQ_DEPTH + 1);

  job_t             slots_r [JQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_wr, do_rd;

  assign full   = (count_r == CNT_W'(JQ_DEPTH));
  assign empty  = (count_r == '0);
  assign do_wr  = wr_en && !full;
  assign do_rd  = rd_en && !empty;
  assign rd_job = slots_r[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots_r[wr_ptr_r] <= wr_job;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_rd) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_wr && !do_rd)      count_r <= count_r + 1'b1;
      else if (do_rd && !do_wr) count_r <= count_r - 1'b1;
    end
  end

endmodule

// ----- design/xcfb_back.sv -----
// Back end: expands jobs into frame bytes, keeps the checksum and the output register.
`timescale 1ns / 1ps

module xcfb_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  logic [7:0]     cfg_wdata,
  input  logic           job_valid,
  input  xcfb_pkg::job_t job,
  output logic           job_done,
  input  logic           pop,
  output logic           empty,
  output logic [7:0]     out_byte,
  output logic           out_run_last,
  output logic           out_frame_end,
  output logic           out_error
);
  import xcfb_pkg::*;

  // Last step of each run
  localparam logic [STEP_W-1:0] START_HDR_LAST = STEP_W'(5);
  localparam logic [STEP_W-1:0] START_TRL_LAST = STEP_W'(7);
  localparam logic [STEP_W-1:0] DATA_TRL_LAST  = STEP_W'(2);

  logic [7:0]        master_token_r, slave_token_r;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [7:0]        xor_r, xor_nxt;
  logic              out_valid_r;
  logic [7:0]        byte_r;
  logic              run_last_r, frame_end_r, error_r;

  byte_sel_t  sel;
  logic       last_step;
  logic       advance;
  logic [7:0] cur_byte;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      master_token_r <= 8'd0;
      slave_token_r  <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MASTER_TOKEN: master_token_r <= cfg_wdata;
        REG_SLAVE_TOKEN:  slave_token_r  <= cfg_wdata;
        default:          ;
      endcase
    end
  end

  // Pick the byte for the current step of the job
  always_comb begin
    sel       = SEL_ERR;
    last_step = 1'b1;
    case (job.kind)
      JOB_START: begin
        case (step_r)
          3'd0:    sel = SEL_FLAG;
          3'd1:    sel = SEL_LEN4;
          3'd2:    sel = SEL_CMD;
          3'd3:    sel = SEL_LEN;
          3'd4:    sel = SEL_MTOK;
          3'd5:    sel = SEL_STOK;
          3'd6:    sel = SEL_XOR;
          default: sel = SEL_CLOSE;
        endcase
        last_step = (step_r == (job.trailer ? START_TRL_LAST : START_HDR_LAST));
      end
      JOB_DATA: begin
        case (step_r)
          3'd0:    sel = SEL_DATA;
          3'd1:    sel = SEL_XOR;
          default: sel = SEL_CLOSE;
        endcase
        last_step = job.trailer ? (step_r == DATA_TRL_LAST) : 1'b1;
      end
      default: begin
        sel       = SEL_ERR;
        last_step = 1'b1;
      end
    endcase
  end

  // Byte value and checksum update
  always_comb begin
    cur_byte = 8'd0;
    xor_nxt  = xor_r;
    case (sel)
      SEL_FLAG: begin
        cur_byte = FRAME_FLAG;
        xor_nxt  = 8'd0;
      end
      SEL_LEN4: begin
        cur_byte = {1'b0, job.length} + LEN_OFFSET;
        xor_nxt  = xor_r ^ cur_byte;
      end
      SEL_CMD: begin
        cur_byte = job.command;
        xor_nxt  = xor_r ^ cur_byte;
      end
      SEL_LEN: begin
        cur_byte = {1'b0, job.length};
        xor_nxt  = xor_r ^ cur_byte;
      end
      SEL_MTOK: begin
        cur_byte = master_token_r;
        xor_nxt  = xor_r ^ cur_byte;
      end
      SEL_STOK: begin
        cur_byte = slave_token_r;
        xor_nxt  = xor_r ^ cur_byte;
      end
      SEL_DATA: begin
        cur_byte = job.data;
        xor_nxt  = xor_r ^ cur_byte;
      end
      SEL_XOR: begin
        cur_byte = xor_r;
      end
      SEL_CLOSE: begin
        cur_byte = FRAME_FLAG;
        xor_nxt  = 8'd0;
      end
      default: begin
        cur_byte = 8'd0;
      end
    endcase
  end

  // One byte moves into the output register when it is free or being taken
  assign advance  = job_valid && (!out_valid_r || pop);
  assign job_done = advance && last_step;
  assign step_nxt = last_step ? '0 : step_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      xor_r       <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        step_r      <= step_nxt;
        xor_r       <= xor_nxt;
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (advance) begin
      byte_r      <= cur_byte;
      run_last_r  <= last_step;
      frame_end_r <= (sel == SEL_CLOSE);
      error_r     <= (sel == SEL_ERR);
    end
  end

  assign empty         = !out_valid_r;
  assign out_byte      = byte_r;
  assign out_run_last  = run_last_r;
  assign out_frame_end = frame_end_r;
  assign out_error     = error_r;

endmodule

// ----- design/xor_checked_frame_builder.sv -----
// Top level of the flag-delimited frame builder with XOR checksum.
// The first result of an item passes through the job queue and then the output register.
// The byte sequencer sends one byte per cycle while the output is free or being popped;
// bytes per item: data 1, or 3 when closing; start 6, or 8 with a zero length; error 1.
// The input side takes one item per cycle until the four-entry job queue fills.
// Reset (synchronous, active low) closes any frame, empties the queue and zeroes the tokens.
`timescale 1ns / 1ps

module xor_checked_frame_builder #(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  // Configuration
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_wdata,
  // Input items
  input  logic       push,
  output logic       full,
  input  logic       in_opcode,
  input  logic [7:0] in_command,
  input  logic [6:0] in_payload_length,
  input  logic [7:0] in_data_byte,
  // Result items
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       out_run_last,
  output logic       out_frame_end,
  output logic       out_error
);
  import xcfb_pkg::*;

  job_t front_job, head_job;
  logic accept;
  logic q_empty;
  logic job_done;

  assign accept = push && !full;

  xcfb_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .opcode         (in_opcode),
    .command        (in_command),
    .payload_length (in_payload_length),
    .data_byte      (in_data_byte),
    .job            (front_job)
  );

  xcfb_job_fifo u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (accept),
    .wr_job (front_job),
    .rd_en  (job_done),
    .rd_job (head_job),
    .full   (full),
    .empty  (q_empty)
  );

  xcfb_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .job_valid     (!q_empty),
    .job           (head_job),
    .job_done      (job_done),
    .pop           (pop),
    .empty         (empty),
    .out_byte      (out_byte),
    .out_run_last  (out_run_last),
    .out_frame_end (out_frame_end),
    .out_error     (out_error)
  );

endmodule

// ----- design/xcfb_checker.sv -----
// Port-level checks for the frame builder, bound to the top level.
`timescale 1ns / 1ps

module xcfb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte,
  input logic       out_run_last,
  input logic       out_frame_end,
  input logic       out_error
);

  // A waiting result holds until it is taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(out_run_last) &&
                          $stable(out_frame_end) && $stable(out_error)))
    else $error("waiting result changed before it was taken");

  // Reset leaves no result waiting
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result shown right after reset");

  // An error is a lone result with a zero byte and no closing flag
  a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_error) |-> (out_run_last && !out_frame_end && out_byte == 8'd0))
    else $error("malformed error result");

  // The closing flag ends its item's run and carries the flag value
  a_close_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_frame_end) |-> (out_run_last && out_byte == 8'h7E))
    else $error("closing flag not last or wrong value");

  // Once a closing flag is taken, the next result shown is never another closing flag
  a_close_after_xor: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && pop && out_frame_end) |=> (empty || !out_frame_end))
    else $error("two closing flags in a row");

endmodule

bind xor_checked_frame_builder xcfb_checker u_xcfb_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .empty         (empty),
  .pop           (pop),
  .out_byte      (out_byte),
  .out_run_last  (out_run_last),
  .out_frame_end (out_frame_end),
  .out_error     (out_error)
);
